[sv/cfr_pkg.sv]
// Shared types, constants and helper functions for the comb filter reverb.
package cfr_pkg;

	localparam int NUM_LINES = 4;
	localparam int LINE_W = 2;
	localparam int unsigned LINE_MS [NUM_LINES] = '{29, 37, 43, 53};
	localparam int MS_DIVISOR = 1000;

	localparam int SMP_W = 16;
	localparam int DATA_W = 32;
	localparam int RATE_W = 16;
	localparam int MS_W = 6;
	localparam int DVD_W = RATE_W + MS_W;

	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SAT_IN_W = MUL_P_W + 1;

	localparam int G_BASE = 11469;
	localparam int G_SCALE = 18022;
	localparam int FRAC_BITS = 15;
	localparam int LINE_FRAC = 12;
	localparam int DRY_SHIFT = 14;
	localparam int MIX_SHIFT = 29;

	localparam logic signed [SAT_IN_W-1:0] SAT32_HI = SAT_IN_W'(64'sd2147483647);
	localparam logic signed [SAT_IN_W-1:0] SAT32_LO = SAT_IN_W'(-64'sd2147483648);
	localparam logic signed [SAT_IN_W-1:0] SAT16_HI = SAT_IN_W'(64'sd32767);
	localparam logic signed [SAT_IN_W-1:0] SAT16_LO = SAT_IN_W'(-64'sd32768);

	typedef enum logic [2:0] {
		REG_ENABLE      = 3'd0,
		REG_CHANNELS    = 3'd1,
		REG_SAMPLE_RATE = 3'd2,
		REG_ROOM_SIZE   = 3'd3,
		REG_DAMPING     = 3'd4,
		REG_WET_GAIN    = 3'd5,
		REG_DRY_GAIN    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                      start;
		logic signed [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0]        b;
	} mul_req_t;

	typedef struct packed {
		logic                      busy;
		logic                      done;
		logic signed [MUL_P_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_IN_W-1:0] v);
		logic signed [DATA_W-1:0] r;
		if (v > SAT32_HI) begin
			r = DATA_W'(SAT32_HI);
		end else if (v < SAT32_LO) begin
			r = DATA_W'(SAT32_LO);
		end else begin
			r = DATA_W'(v);
		end
		return r;
	endfunction

	function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SAT_IN_W-1:0] v);
		logic signed [SMP_W-1:0] r;
		if (v > SAT16_HI) begin
			r = SMP_W'(SAT16_HI);
		end else if (v < SAT16_LO) begin
			r = SMP_W'(SAT16_LO);
		end else begin
			r = SMP_W'(v);
		end
		return r;
	endfunction

endpackage

[sv/cfr_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module cfr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[sv/cfr_mul.sv]
// Bit-serial signed by unsigned multiplier, one multiplier bit per cycle.
module cfr_mul import cfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(MUL_B_W);

	logic signed [MUL_P_W-1:0] acc_q;
	logic signed [MUL_P_W-1:0] a_sh_q;
	logic [MUL_B_W-1:0]        b_sh_q;
	logic [CNT_W-1:0]          cnt_q;
	logic                      busy_q;
	logic                      done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			a_sh_q <= '0;
			b_sh_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				acc_q  <= '0;
				a_sh_q <= MUL_P_W'(req.a);
				b_sh_q <= req.b;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (b_sh_q[0]) begin
					acc_q <= acc_q + a_sh_q;
				end
				a_sh_q <= a_sh_q <<< 1;
				b_sh_q <= b_sh_q >> 1;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(MUL_B_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, p: acc_q};

endmodule

[sv/cfr_lendiv.sv]
// Restoring bit-serial divider by the millisecond divisor for delay line lengths.
module cfr_lendiv import cfr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int REM_W = $clog2(MS_DIVISOR) + 1;
	localparam int CNT_W = $clog2(DVD_W);

	logic [DVD_W-1:0] dvd_q;
	logic [DVD_W-1:0] quo_q;
	logic [REM_W-2:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W-1:0] trial;
	logic             fits;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign fits  = trial >= REM_W'(MS_DIVISOR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				dvd_q  <= req.dividend;
				quo_q  <= '0;
				rem_q  <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fits ? (REM_W-1)'(trial - REM_W'(MS_DIVISOR)) : (REM_W-1)'(trial);
				quo_q <= {quo_q[DVD_W-2:0], fits};
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp = '{busy: busy_q, done: done_q, quotient: quo_q};

endmodule

[sv/comb_filter_reverb_top.sv]
// Top level of the four-line damped feedback comb reverb.
// Each sample runs through the four comb lines in turn on one shared bit-serial
// multiplier; an item takes eleven products when reverb is enabled, and when it is
// disabled the sample bypasses the multiplier.
// After reset a clearing pass writes zero to every line store, and the line
// lengths are then computed by a serial divider; that computation repeats after
// every write of the channel count or the sample rate.
// No sample is accepted during either phase, while configuration writes are taken
// at any time.
module comb_filter_reverb_top import cfr_pkg::*; #(
	parameter int MAX_CHANNELS = 2,
	parameter int MAX_SAMPLE_RATE = 48000
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [SMP_W-1:0] sample_in,
	input  logic                    block_start,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic signed [SMP_W-1:0] sample_out,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [15:0]             cfg_data
);

	localparam int LEN_MAX = MAX_SAMPLE_RATE * LINE_MS[NUM_LINES-1] / MS_DIVISOR;
	localparam int LEN_W = $clog2(LEN_MAX + 1);
	localparam int DEPTH_MAX = LEN_MAX * MAX_CHANNELS;
	localparam int OFF_W = $clog2(DEPTH_MAX);
	localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LSTART,
		S_LWAIT,
		S_GAIN,
		S_RD,
		S_RDW,
		S_DMUL,
		S_FMUL,
		S_DRY,
		S_WET,
		S_DONE
	} state_t;

	logic                    enable_q;
	logic [1:0]              channels_q;
	logic [RATE_W-1:0]       sample_rate_q;
	logic [15:0]             room_size_q;
	logic [15:0]             damping_q;
	logic [15:0]             wet_gain_q;
	logic [15:0]             dry_gain_q;
	logic                    len_wr;

	state_t                  state_q;
	logic                    dirty_q;
	logic [OFF_W-1:0]        clr_q;
	logic [LINE_W-1:0]       line_q;
	logic signed [SMP_W-1:0] x_q;
	logic [CH_W-1:0]         ch_q;
	logic [CH_W-1:0]         chan_q;
	logic [1:0]              nch_q;
	logic [15:0]             g_q;
	logic [LEN_W-1:0]        pos_q [NUM_LINES];
	logic [LEN_W-1:0]        len_q [NUM_LINES];
	logic [LEN_W-1:0]        pos_eff_q;
	logic [OFF_W-1:0]        off_q;
	logic signed [DATA_W-1:0] damp_q [NUM_LINES][MAX_CHANNELS];
	logic signed [DATA_W+1:0] sum_q;
	logic signed [SMP_W+MUL_B_W:0] dry_q;
	logic signed [SMP_W-1:0] res_q;
	logic signed [SMP_W-1:0] out_q;
	logic                    out_valid_q;

	mul_req_t                mul_req;
	mul_rsp_t                mul_rsp;
	div_req_t                div_req;
	div_rsp_t                div_rsp;

	logic [1:0]              nch_c;
	logic [CH_W-1:0]         ch_raw_c;
	logic [CH_W-1:0]         ch_c;
	logic [LEN_W-1:0]        pos_c;
	logic [OFF_W-1:0]        off_c;
	logic [RATE_W-1:0]       rate_eff_c;
	logic signed [DATA_W-1:0] rd_data [NUM_LINES];
	logic signed [DATA_W-1:0] f_c;
	logic signed [DATA_W:0]  diff_c;
	logic signed [MUL_P_W-1:0] rnd_c;
	logic signed [DATA_W-1:0] damped_c;
	logic signed [DATA_W-1:0] st_c;
	logic signed [SAT_IN_W-1:0] acc_c;
	logic signed [SAT_IN_W-1:0] mag_c;
	logic signed [SAT_IN_W-1:0] y_c;
	logic [LEN_W:0]          pos_next_c;
	logic                    wr_en;
	logic                    accept;

	assign cfg_ready = 1'b1;
	assign len_wr = cfg_valid && ((cfg_reg_t'(cfg_index) == REG_CHANNELS) ||
		(cfg_reg_t'(cfg_index) == REG_SAMPLE_RATE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= 1'b1;
			channels_q    <= 2'd2;
			sample_rate_q <= RATE_W'(48000);
			room_size_q   <= 16'd16384;
			damping_q     <= 16'd16384;
			wet_gain_q    <= 16'd16384;
			dry_gain_q    <= 16'd32768;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_CHANNELS:    channels_q    <= cfg_data[1:0];
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data;
				REG_ROOM_SIZE:   room_size_q   <= cfg_data;
				REG_DAMPING:     damping_q     <= cfg_data;
				REG_WET_GAIN:    wet_gain_q    <= cfg_data;
				REG_DRY_GAIN:    dry_gain_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign nch_c = (channels_q == 2'd0) ? 2'd1 :
		((int'(channels_q) > MAX_CHANNELS) ? 2'(MAX_CHANNELS) : channels_q);
	assign ch_raw_c = block_start ? '0 : chan_q;
	assign ch_c = (int'(ch_raw_c) >= int'(nch_c)) ? '0 : ch_raw_c;
	assign pos_c = (pos_q[line_q] >= len_q[line_q]) ? '0 : pos_q[line_q];
	assign off_c = OFF_W'(OFF_W'(pos_c) * OFF_W'(nch_q) + OFF_W'(ch_q));
	assign rate_eff_c = (int'(sample_rate_q) > MAX_SAMPLE_RATE) ? RATE_W'(MAX_SAMPLE_RATE) :
		sample_rate_q;

	assign f_c = damp_q[line_q][ch_q];
	assign diff_c = (DATA_W+1)'(rd_data[line_q]) - (DATA_W+1)'(f_c);
	assign rnd_c = (mul_rsp.p + MUL_P_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
	assign damped_c = sat32(SAT_IN_W'(f_c) + SAT_IN_W'(rnd_c));
	assign st_c = sat32((SAT_IN_W'(x_q) <<< LINE_FRAC) + SAT_IN_W'(rnd_c));
	assign acc_c = (SAT_IN_W'(dry_q) <<< DRY_SHIFT) + SAT_IN_W'(mul_rsp.p);
	assign mag_c = acc_c[SAT_IN_W-1] ? -acc_c : acc_c;
	assign y_c = acc_c[SAT_IN_W-1] ? -(mag_c >>> MIX_SHIFT) : (mag_c >>> MIX_SHIFT);
	assign pos_next_c = (LEN_W+1)'(pos_eff_q) + 1'b1;

	assign in_ready = (state_q == S_IDLE) && !dirty_q;
	assign accept = in_valid && in_ready;
	assign wr_en = (state_q == S_FMUL) && mul_rsp.done;

	always_comb begin
		mul_req = '0;
		div_req = '0;
		unique case (state_q)
			S_IDLE: begin
				mul_req.start = accept && enable_q;
				mul_req.a     = MUL_A_W'(G_SCALE);
				mul_req.b     = room_size_q;
			end
			S_LSTART: begin
				div_req.start    = 1'b1;
				div_req.dividend = DVD_W'(32'(rate_eff_c) * LINE_MS[line_q]);
			end
			S_RDW: begin
				mul_req.start = 1'b1;
				mul_req.a     = MUL_A_W'(diff_c);
				mul_req.b     = damping_q;
			end
			S_DMUL: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = MUL_A_W'(damped_c);
				mul_req.b     = g_q;
			end
			S_FMUL: begin
				mul_req.start = mul_rsp.done && (line_q == LINE_W'(NUM_LINES - 1));
				mul_req.a     = MUL_A_W'(x_q);
				mul_req.b     = dry_gain_q;
			end
			S_DRY: begin
				mul_req.start = mul_rsp.done;
				mul_req.a     = MUL_A_W'(sum_q);
				mul_req.b     = wet_gain_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			dirty_q     <= 1'b1;
			clr_q       <= '0;
			line_q      <= '0;
			x_q         <= '0;
			ch_q        <= '0;
			chan_q      <= '0;
			nch_q       <= 2'd1;
			g_q         <= '0;
			pos_eff_q   <= '0;
			off_q       <= '0;
			sum_q       <= '0;
			dry_q       <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
			for (int l = 0; l < NUM_LINES; l++) begin
				pos_q[l] <= '0;
				len_q[l] <= '0;
				for (int c = 0; c < MAX_CHANNELS; c++) begin
					damp_q[l][c] <= '0;
				end
			end
		end else begin
			dirty_q <= len_wr || (dirty_q && (state_q != S_IDLE));
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == DEPTH_MAX - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (dirty_q) begin
						line_q  <= '0;
						state_q <= S_LSTART;
					end else if (in_valid) begin
						x_q   <= sample_in;
						ch_q  <= ch_c;
						nch_q <= nch_c;
						sum_q <= '0;
						if (enable_q) begin
							state_q <= S_GAIN;
						end else begin
							res_q   <= sample_in;
							state_q <= S_DONE;
						end
					end
				end
				S_LSTART: begin
					state_q <= S_LWAIT;
				end
				S_LWAIT: begin
					if (div_rsp.done) begin
						len_q[line_q] <= (div_rsp.quotient == '0) ? LEN_W'(1) :
							LEN_W'(div_rsp.quotient);
						if (line_q == LINE_W'(NUM_LINES - 1)) begin
							for (int l = 0; l < NUM_LINES; l++) begin
								pos_q[l] <= '0;
							end
							chan_q  <= '0;
							line_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							line_q  <= line_q + 1'b1;
							state_q <= S_LSTART;
						end
					end
				end
				S_GAIN: begin
					if (mul_rsp.done) begin
						g_q     <= 16'(MUL_P_W'(G_BASE) + rnd_c);
						line_q  <= '0;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					pos_eff_q <= pos_c;
					off_q     <= off_c;
					state_q   <= S_RDW;
				end
				S_RDW: begin
					state_q <= S_DMUL;
				end
				S_DMUL: begin
					if (mul_rsp.done) begin
						damp_q[line_q][ch_q] <= damped_c;
						sum_q   <= sum_q + (DATA_W+2)'(damped_c);
						state_q <= S_FMUL;
					end
				end
				S_FMUL: begin
					if (mul_rsp.done) begin
						if (int'(ch_q) + 1 == int'(nch_q)) begin
							pos_q[line_q] <= (pos_next_c >= (LEN_W+1)'(len_q[line_q])) ? '0 :
								LEN_W'(pos_next_c);
						end else begin
							pos_q[line_q] <= pos_eff_q;
						end
						if (line_q == LINE_W'(NUM_LINES - 1)) begin
							state_q <= S_DRY;
						end else begin
							line_q  <= line_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_DRY: begin
					if (mul_rsp.done) begin
						dry_q   <= (SMP_W+MUL_B_W+1)'(mul_rsp.p);
						state_q <= S_WET;
					end
				end
				S_WET: begin
					if (mul_rsp.done) begin
						res_q   <= sat16(y_c);
						chan_q  <= (int'(ch_q) + 1 == int'(nch_q)) ? '0 : ch_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign sample_out = out_q;
	assign out_valid = out_valid_q;

	cfr_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	cfr_lendiv u_lendiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	for (genvar i = 0; i < NUM_LINES; i++) begin : g_line
		localparam int LMAX = MAX_SAMPLE_RATE * LINE_MS[i] / MS_DIVISOR;
		localparam int DEPTH = LMAX * MAX_CHANNELS;
		localparam int AW = $clog2(DEPTH);

		logic              we;
		logic              re;
		logic [AW-1:0]     waddr;
		logic [DATA_W-1:0] wdata;
		logic [DATA_W-1:0] rdata;

		assign we = (state_q == S_CLEAR) ? (int'(clr_q) < DEPTH) :
			(wr_en && (line_q == LINE_W'(i)));
		assign waddr = (state_q == S_CLEAR) ? clr_q[AW-1:0] : off_q[AW-1:0];
		assign wdata = (state_q == S_CLEAR) ? '0 : st_c;
		assign re = (state_q == S_RD) && (line_q == LINE_W'(i));
		assign rd_data[i] = rdata;

		cfr_ram #(
			.WIDTH (DATA_W),
			.DEPTH (DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (waddr),
			.wdata (wdata),
			.re    (re),
			.raddr (off_c[AW-1:0]),
			.rdata (rdata)
		);
	end

`ifndef SYNTHESIS
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted transaction did not start processing");

	a_mul_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("output transaction raised outside completion");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_LWAIT))
		else $error("length result arrived outside length computation");
`endif

endmodule
